// ===== rtl/ps2kr_pkg.sv =====
// Shared types and constants for the PS/2 keyboard receiver.
package ps2kr_pkg;

  localparam logic [7:0] CodeRelease = 8'hF0;
  localparam logic [7:0] CodeExtend  = 8'hE0;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned ModW    = 6;
  localparam int unsigned LockW   = 3;

  // modifier_flags bit positions
  localparam logic [2:0] ModScroll = 3'd0;
  localparam logic [2:0] ModNum    = 3'd1;
  localparam logic [2:0] ModCaps   = 3'd2;
  localparam logic [2:0] ModShift  = 3'd3;
  localparam logic [2:0] ModAlt    = 3'd4;
  localparam logic [2:0] ModCtrl   = 3'd5;

  // result queue sizing
  localparam int unsigned QDepth = 3;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCROLL      = 3'd0,
    REG_NUM         = 3'd1,
    REG_CAPS        = 3'd2,
    REG_LEFT_SHIFT  = 3'd3,
    REG_RIGHT_SHIFT = 3'd4,
    REG_ALT         = 3'd5,
    REG_CTRL        = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_ONE  = 2'd1,
    PFX_TWO  = 2'd2
  } prefix_t;

  typedef struct packed {
    logic [CodeW-1:0] scroll;
    logic [CodeW-1:0] num;
    logic [CodeW-1:0] caps;
    logic [CodeW-1:0] left_shift;
    logic [CodeW-1:0] right_shift;
    logic [CodeW-1:0] alt;
    logic [CodeW-1:0] ctrl;
  } cfg_regs_t;

  localparam cfg_regs_t CfgReset = '{
    scroll:      8'd126,
    num:         8'd119,
    caps:        8'd88,
    left_shift:  8'd18,
    right_shift: 8'd89,
    alt:         8'd17,
    ctrl:        8'd20
  };

  typedef struct packed {
    logic               en;
    logic [CfgIdxW-1:0] index;
    logic [CodeW-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] data;
  } frame_byte_t;

  typedef struct packed {
    logic [CodeW-1:0] scancode;
    logic [1:0]       sequence_length;
    logic             released;
    logic             extended;
    logic [ModW-1:0]  modifier_flags;
  } result_t;

endpackage

// ===== rtl/ps2kr_ifs.sv =====
// Handshake channel interfaces: sampled bit in, sequence result out, register writes.
interface ps2kr_in_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink (input valid, input data_bit, output ready);
endinterface

interface ps2kr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;
  logic [1:0] sequence_length;
  logic       released;
  logic       extended;
  logic [5:0] modifier_flags;

  modport source (output valid, output scancode, output sequence_length, output released,
                  output extended, output modifier_flags, input ready);
  modport sink (input valid, input scancode, input sequence_length, input released,
                input extended, input modifier_flags, output ready);
endinterface

interface ps2kr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ps2_keyboard_receiver.sv =====
// PS/2 keyboard receiver: top level with input register and result queue.
// Usage
//   in_if  : one word per keyboard-clock falling edge, data_bit = data line level.
//   out_if : one word per completed scancode sequence (plain, F0 x, E0 x, E0 F0 x),
//            carrying the final scancode, length, released/extended and the
//            modifier flags after that key's update.
//   cfg_if : register writes, index 0..6 = scroll, num, caps, left shift,
//            right shift, alt, ctrl codes; always ready, out-of-range index ignored.
// Timing
//   A word is registered on acceptance and processed in the next cycle; the stop
//   bit of a frame that completes a sequence passes the input register, and its
//   result is written into the queue, which raises out_if.valid. One word per cycle
//   is taken while in_if.ready is high. Bad frames (parity or stop bit) give no result.
// Stalls
//   Results go into a three-entry queue; in_if.ready drops only when queued
//   results plus the word in the input register fill it, so out_if.ready never
//   reaches in_if.ready combinationally.
// Reset
//   rst_n (synchronous, active low) clears frame, prefix, modifier and lock state,
//   empties the queue and restores the default key codes.
module ps2_keyboard_receiver (
  input  logic         clk,
  input  logic         rst_n,
  ps2kr_in_if.sink     in_if,
  ps2kr_out_if.source  out_if,
  ps2kr_cfg_if.sink    cfg_if
);

  logic                          in_valid_r;
  logic                          in_bit_r;
  logic                          in_acc;

  ps2kr_pkg::cfg_wr_t            cfg_wr;
  ps2kr_pkg::frame_byte_t        frame_byte;
  logic                          res_valid;
  ps2kr_pkg::result_t            res;

  ps2kr_pkg::result_t            q_mem_r [ps2kr_pkg::QDepth];
  logic [ps2kr_pkg::QIdxW-1:0]   head_r, head_nxt;
  logic [ps2kr_pkg::QIdxW-1:0]   tail_r, tail_nxt;
  logic [ps2kr_pkg::QCntW-1:0]   cnt_r, cnt_nxt;
  logic                          push;
  logic                          pop;
  logic [ps2kr_pkg::QCntW:0]     occupancy;

  localparam logic [ps2kr_pkg::QIdxW-1:0] QLast  = ps2kr_pkg::QIdxW'(ps2kr_pkg::QDepth - 1);
  localparam logic [ps2kr_pkg::QCntW:0]   QLimit = (ps2kr_pkg::QCntW + 1)'(ps2kr_pkg::QDepth);

  assign cfg_if.ready = 1'b1;
  assign cfg_wr.en    = cfg_if.valid;
  assign cfg_wr.index = cfg_if.index;
  assign cfg_wr.data  = cfg_if.data;

  // count the word in the input register as a possible result
  assign occupancy   = {1'b0, cnt_r} + {{ps2kr_pkg::QCntW{1'b0}}, in_valid_r};
  assign in_if.ready = occupancy < QLimit;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_bit_r <= in_if.data_bit;
    end
  end

  ps2kr_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_valid_r),
    .data_bit (in_bit_r),
    .byte_out (frame_byte)
  );

  ps2kr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .byte_in   (frame_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  assign push = res_valid;
  assign pop  = out_if.valid && out_if.ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == QLast) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == QLast) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[tail_r] <= res;
    end
  end

  assign out_if.valid           = cnt_r != '0;
  assign out_if.scancode        = q_mem_r[head_r].scancode;
  assign out_if.sequence_length = q_mem_r[head_r].sequence_length;
  assign out_if.released        = q_mem_r[head_r].released;
  assign out_if.extended        = q_mem_r[head_r].extended;
  assign out_if.modifier_flags  = q_mem_r[head_r].modifier_flags;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != ps2kr_pkg::QCntW'(ps2kr_pkg::QDepth))
    else $error("result queue overflow");

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_valid_r)
    else $error("result without a word in the input register");

  a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> head_r == tail_r)
    else $error("queue pointers disagree with empty count");

  a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready && pop && !push |=> in_if.ready)
    else $error("input stays blocked after a result is taken");
`endif

endmodule

// ===== rtl/ps2kr_frame.sv =====
// Frame deserialiser: start bit, eight data bits LSB first, odd parity, stop bit.
module ps2kr_frame (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     data_bit,
  output ps2kr_pkg::frame_byte_t   byte_out
);

  logic                          in_frame_r, in_frame_nxt;
  logic [3:0]                    bit_pos_r, bit_pos_nxt;
  logic [ps2kr_pkg::CodeW-1:0]   shift_r, shift_nxt;
  logic                          parity_r, parity_nxt;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    bit_pos_nxt    = bit_pos_r;
    shift_nxt      = shift_r;
    parity_nxt     = parity_r;
    byte_out.valid = 1'b0;
    byte_out.data  = shift_r;
    if (step) begin
      if (!in_frame_r) begin
        // idle-high bits are skipped until a start bit
        if (!data_bit) begin
          in_frame_nxt = 1'b1;
          bit_pos_nxt  = 4'd0;
          shift_nxt    = '0;
          parity_nxt   = 1'b0;
        end
      end else if (bit_pos_r < 4'd8) begin
        shift_nxt   = {data_bit, shift_r[ps2kr_pkg::CodeW-1:1]};
        parity_nxt  = parity_r ^ data_bit;
        bit_pos_nxt = bit_pos_r + 4'd1;
      end else if (bit_pos_r == 4'd8) begin
        parity_nxt  = parity_r ^ data_bit;
        bit_pos_nxt = 4'd9;
      end else begin
        byte_out.valid = data_bit && parity_r;
        in_frame_nxt   = 1'b0;
        bit_pos_nxt    = 4'd0;
        shift_nxt      = '0;
        parity_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      bit_pos_r  <= 4'd0;
      shift_r    <= '0;
      parity_r   <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      bit_pos_r  <= bit_pos_nxt;
      shift_r    <= shift_nxt;
      parity_r   <= parity_nxt;
    end
  end

endmodule

// ===== rtl/ps2kr_seq.sv =====
// Sequence assembler: prefix tracking, key-code registers and modifier state.
module ps2kr_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ps2kr_pkg::cfg_wr_t      cfg_wr,
  input  ps2kr_pkg::frame_byte_t  byte_in,
  output logic                    res_valid,
  output ps2kr_pkg::result_t      res
);

  ps2kr_pkg::cfg_regs_t          regs_r, regs_nxt;
  ps2kr_pkg::prefix_t            pfx_r, pfx_nxt;
  logic                          fext_r, fext_nxt;
  logic [ps2kr_pkg::ModW-1:0]    mods_r, mods_nxt;
  logic [ps2kr_pkg::LockW-1:0]   held_r, held_nxt;

  logic [ps2kr_pkg::CodeW-1:0]   b;
  logic                          is_prefix;
  logic                          emit;
  logic                          up;
  logic [1:0]                    seq_len;
  logic                          seq_ext;
  logic                          lock_hit;
  logic [1:0]                    lock_idx;
  logic                          plain_hit;
  logic [2:0]                    plain_idx;

  assign b = byte_in.data;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_wr.en) begin
      case (ps2kr_pkg::cfg_reg_t'(cfg_wr.index))
        ps2kr_pkg::REG_SCROLL:      regs_nxt.scroll      = cfg_wr.data;
        ps2kr_pkg::REG_NUM:         regs_nxt.num         = cfg_wr.data;
        ps2kr_pkg::REG_CAPS:        regs_nxt.caps        = cfg_wr.data;
        ps2kr_pkg::REG_LEFT_SHIFT:  regs_nxt.left_shift  = cfg_wr.data;
        ps2kr_pkg::REG_RIGHT_SHIFT: regs_nxt.right_shift = cfg_wr.data;
        ps2kr_pkg::REG_ALT:         regs_nxt.alt         = cfg_wr.data;
        ps2kr_pkg::REG_CTRL:        regs_nxt.ctrl        = cfg_wr.data;
        default: ;
      endcase
    end
  end

  // prefix state machine: next state
  always_comb begin
    pfx_nxt  = pfx_r;
    fext_nxt = fext_r;
    if (byte_in.valid) begin
      case (pfx_r)
        ps2kr_pkg::PFX_NONE: begin
          if (is_prefix) begin
            pfx_nxt  = ps2kr_pkg::PFX_ONE;
            fext_nxt = (b == ps2kr_pkg::CodeExtend);
          end
        end
        ps2kr_pkg::PFX_ONE: begin
          if (b == ps2kr_pkg::CodeRelease) begin
            pfx_nxt = ps2kr_pkg::PFX_TWO;
          end
        end
        default: ;
      endcase
      if (emit) begin
        pfx_nxt  = ps2kr_pkg::PFX_NONE;
        fext_nxt = 1'b0;
      end
    end
  end

  // prefix state machine: outputs
  always_comb begin
    is_prefix = (b == ps2kr_pkg::CodeRelease) || (b == ps2kr_pkg::CodeExtend);
    emit      = 1'b0;
    up        = 1'b0;
    seq_len   = 2'd1;
    seq_ext   = 1'b0;
    case (pfx_r)
      ps2kr_pkg::PFX_NONE: begin
        emit = byte_in.valid && !is_prefix;
      end
      ps2kr_pkg::PFX_ONE: begin
        emit    = byte_in.valid && (b != ps2kr_pkg::CodeRelease);
        seq_len = 2'd2;
        up      = !fext_r;
        seq_ext = fext_r;
      end
      default: begin
        // also covers the unused encoding
        emit    = byte_in.valid;
        seq_len = 2'd3;
        up      = 1'b1;
        seq_ext = fext_r;
      end
    endcase
    res_valid = emit;
  end

  // key match, first hit wins
  always_comb begin
    lock_hit  = 1'b0;
    lock_idx  = 2'd0;
    plain_hit = 1'b0;
    plain_idx = ps2kr_pkg::ModShift;
    if (b == regs_r.scroll) begin
      lock_hit = 1'b1;
      lock_idx = ps2kr_pkg::ModScroll[1:0];
    end else if (b == regs_r.num) begin
      lock_hit = 1'b1;
      lock_idx = ps2kr_pkg::ModNum[1:0];
    end else if (b == regs_r.caps) begin
      lock_hit = 1'b1;
      lock_idx = ps2kr_pkg::ModCaps[1:0];
    end else if (b == regs_r.left_shift || b == regs_r.right_shift) begin
      plain_hit = 1'b1;
      plain_idx = ps2kr_pkg::ModShift;
    end else if (b == regs_r.alt) begin
      plain_hit = 1'b1;
      plain_idx = ps2kr_pkg::ModAlt;
    end else if (b == regs_r.ctrl) begin
      plain_hit = 1'b1;
      plain_idx = ps2kr_pkg::ModCtrl;
    end
  end

  always_comb begin
    mods_nxt = mods_r;
    held_nxt = held_r;
    if (emit) begin
      if (lock_hit) begin
        if (!up) begin
          // toggle only on a fresh press, not on typematic repeat
          if (!held_r[lock_idx]) begin
            held_nxt[lock_idx] = 1'b1;
            mods_nxt[lock_idx] = ~mods_r[lock_idx];
          end
        end else begin
          held_nxt[lock_idx] = 1'b0;
        end
      end else if (plain_hit) begin
        mods_nxt[plain_idx] = !up;
      end
    end
  end

  assign res = '{scancode:        b,
                 sequence_length: seq_len,
                 released:        up,
                 extended:        seq_ext,
                 modifier_flags:  mods_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= ps2kr_pkg::CfgReset;
      pfx_r  <= ps2kr_pkg::PFX_NONE;
      fext_r <= 1'b0;
      mods_r <= '0;
      held_r <= '0;
    end else begin
      regs_r <= regs_nxt;
      pfx_r  <= pfx_nxt;
      fext_r <= fext_nxt;
      mods_r <= mods_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== test/scancode_checker.sv =====
// Scancode checker: follows the bit, result and register channels, predicts and compares.
module scancode_checker import ps2kr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ps2kr_in_if    in_ch,
  ps2kr_out_if   out_ch,
  ps2kr_cfg_if   cfg_ch,
  output int     mismatches,
  output int     outstanding
);

  localparam int unsigned DataBits = 8;

  cfg_regs_t         key_codes;
  logic              in_frame;
  logic [3:0]        bit_pos;
  logic [CodeW-1:0]  shift_reg;
  logic              parity_acc;
  prefix_t           prefix;
  logic              first_ext;
  logic [ModW-1:0]   mods;
  logic [LockW-1:0]  locks_down;
  result_t           expected_keys[$];

  // lock keys toggle only on a fresh press
  task automatic update_lock(input logic up, input logic [2:0] pos);
    if (!up) begin
      if (!locks_down[pos]) begin
        locks_down[pos] = 1'b1;
        mods[pos] = ~mods[pos];
      end
    end else begin
      locks_down[pos] = 1'b0;
    end
  endtask

  task automatic finish_byte(input logic [CodeW-1:0] b);
    result_t    r;
    logic       up;
    logic       ext;
    logic [1:0] len;
    case (prefix)
      PFX_NONE: begin
        if (b == CodeRelease || b == CodeExtend) begin
          prefix = PFX_ONE;
          first_ext = (b == CodeExtend);
          return;
        end
        len = 2'd1;
        up = 1'b0;
        ext = 1'b0;
      end
      PFX_ONE: begin
        if (b == CodeRelease) begin
          prefix = PFX_TWO;
          return;
        end
        len = 2'd2;
        up = !first_ext;
        ext = first_ext;
      end
      default: begin
        len = 2'd3;
        up = 1'b1;
        ext = first_ext;
      end
    endcase
    prefix = PFX_NONE;
    first_ext = 1'b0;
    // first match wins, extended or not
    if (b == key_codes.scroll) update_lock(up, ModScroll);
    else if (b == key_codes.num) update_lock(up, ModNum);
    else if (b == key_codes.caps) update_lock(up, ModCaps);
    else if (b == key_codes.left_shift || b == key_codes.right_shift) mods[ModShift] = !up;
    else if (b == key_codes.alt) mods[ModAlt] = !up;
    else if (b == key_codes.ctrl) mods[ModCtrl] = !up;
    r.scancode = b;
    r.sequence_length = len;
    r.released = up;
    r.extended = ext;
    r.modifier_flags = mods;
    expected_keys.push_back(r);
  endtask

  task automatic sample_line(input logic d);
    logic             good;
    logic [CodeW-1:0] b;
    if (!in_frame) begin
      // idle high is ignored
      if (!d) begin
        in_frame = 1'b1;
        bit_pos = '0;
        shift_reg = '0;
        parity_acc = 1'b0;
      end
    end else if (bit_pos < DataBits) begin
      shift_reg[bit_pos[2:0]] = d;
      parity_acc ^= d;
      bit_pos++;
    end else if (bit_pos == DataBits) begin
      parity_acc ^= d;
      bit_pos = 4'(DataBits + 1);
    end else begin
      good = d && parity_acc;
      b = shift_reg;
      in_frame = 1'b0;
      bit_pos = '0;
      shift_reg = '0;
      parity_acc = 1'b0;
      if (good) finish_byte(b);
    end
  endtask

  function automatic int field_differs(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      key_codes = CfgReset;
      in_frame = 1'b0;
      bit_pos = '0;
      shift_reg = '0;
      parity_acc = 1'b0;
      prefix = PFX_NONE;
      first_ext = 1'b0;
      mods = '0;
      locks_down = '0;
      expected_keys.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: key word expected none, got %0h len %0d rel %0b ext %0b mods %0h",
                   $time, out_ch.scancode, out_ch.sequence_length, out_ch.released,
                   out_ch.extended, out_ch.modifier_flags);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          mismatches += field_differs("scancode", want.scancode, out_ch.scancode);
          mismatches += field_differs("sequence_length", 8'(want.sequence_length),
                                      8'(out_ch.sequence_length));
          mismatches += field_differs("released", 8'(want.released), 8'(out_ch.released));
          mismatches += field_differs("extended", 8'(want.extended), 8'(out_ch.extended));
          mismatches += field_differs("modifier_flags", 8'(want.modifier_flags),
                                      8'(out_ch.modifier_flags));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_SCROLL:      key_codes.scroll = cfg_ch.data;
          REG_NUM:         key_codes.num = cfg_ch.data;
          REG_CAPS:        key_codes.caps = cfg_ch.data;
          REG_LEFT_SHIFT:  key_codes.left_shift = cfg_ch.data;
          REG_RIGHT_SHIFT: key_codes.right_shift = cfg_ch.data;
          REG_ALT:         key_codes.alt = cfg_ch.data;
          REG_CTRL:        key_codes.ctrl = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) sample_line(in_ch.data_bit);
    end
    outstanding = expected_keys.size();
  end

endmodule

// ===== test/testbench.sv =====
// Testbench top: clock, reset, key stimulus, receiver stalls and the verdict.
module testbench;
  import ps2kr_pkg::*;

  localparam int unsigned NumKeyRegs = 7;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned PhaseBits  = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldKeys   = 40;

  typedef enum {FRAME_OK, FRAME_BAD_PARITY, FRAME_BAD_STOP} frame_flaw_t;
  typedef enum {SEQ_PRESS, SEQ_RELEASE, SEQ_EXT_PRESS, SEQ_EXT_RELEASE} key_seq_t;
  typedef enum {CODES_ZERO, CODES_ONES, CODES_RANDOM, CODES_PREFIXES, CODES_DEFAULT} code_set_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   bits_sent;
  int   sender_calm;
  logic steady;
  logic hold_request;
  logic [CodeW-1:0] key_pool [NumKeyRegs];

  ps2kr_in_if  in_ch ();
  ps2kr_out_if out_ch ();
  ps2kr_cfg_if cfg_ch ();

  ps2_keyboard_receiver DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  scancode_checker scancode_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // receiver: mostly short stalls, a few long, calm runs, and one long hold-off on request
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ch.ready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(30, 150);
        if (r < 65) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (steady) return 0;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) sender_calm = $urandom_range(30, 150);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [CodeW-1:0] default_code(int i);
    case (cfg_reg_t'(i))
      REG_SCROLL:      return CfgReset.scroll;
      REG_NUM:         return CfgReset.num;
      REG_CAPS:        return CfgReset.caps;
      REG_LEFT_SHIFT:  return CfgReset.left_shift;
      REG_RIGHT_SHIFT: return CfgReset.right_shift;
      REG_ALT:         return CfgReset.alt;
      REG_CTRL:        return CfgReset.ctrl;
      default:         return 8'h00;
    endcase
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return key_pool[$urandom_range(0, NumKeyRegs - 1)];
    if (r < 62) return (r[0]) ? CodeRelease : CodeExtend;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_bit(input logic d);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_bit <= d;
    do @(posedge clk); while (!in_ch.ready);
    bits_sent++;
  endtask

  task automatic send_byte(input logic [CodeW-1:0] b, input frame_flaw_t flaw = FRAME_OK);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_bit(1'b1);
    send_bit(1'b0);
    for (int i = 0; i < 8; i++) send_bit(b[i]);
    send_bit(~^b ^ (flaw == FRAME_BAD_PARITY));
    send_bit(flaw != FRAME_BAD_STOP);
  endtask

  task automatic send_key(input key_seq_t kind, input logic [CodeW-1:0] code);
    if (kind == SEQ_EXT_PRESS || kind == SEQ_EXT_RELEASE) send_byte(CodeExtend);
    if (kind == SEQ_RELEASE || kind == SEQ_EXT_RELEASE) send_byte(CodeRelease);
    send_byte(code);
  endtask

  task automatic random_traffic(input int goal);
    int start;
    int r;
    start = bits_sent;
    while (bits_sent - start < goal) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_key(key_seq_t'($urandom_range(0, 3)), pick_code());
      end else if (r < 90) begin
        send_byte(pick_code(), frame_flaw_t'($urandom_range(1, 2)));
      end else begin
        repeat ($urandom_range(1, 12)) send_bit(1'($urandom));
        // ten ones always bring the framer back to idle
        repeat (10) send_bit(1'b1);
      end
    end
  endtask

  // lower valid, then wait for every expected word to come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < NumKeyRegs) key_pool[idx] = val;
  endtask

  task automatic load_codes(input code_set_t set);
    logic [CodeW-1:0] val;
    for (int i = 0; i < NumKeyRegs; i++) begin
      case (set)
        CODES_ZERO:     val = 8'h00;
        CODES_ONES:     val = 8'hFF;
        CODES_RANDOM:   val = 8'($urandom_range(0, 255));
        CODES_PREFIXES: begin
          if (cfg_reg_t'(i) == REG_SCROLL) val = CodeExtend;
          else if (cfg_reg_t'(i) == REG_NUM) val = CodeRelease;
          else val = 8'($urandom_range(0, 255));
        end
        default:        val = default_code(i);
      endcase
      write_reg(cfg_reg_t'(i), val);
    end
    if (set == CODES_RANDOM) write_reg(RegUnused, 8'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    code_set_t order [5];
    order = '{CODES_RANDOM, CODES_ZERO, CODES_ONES, CODES_PREFIXES, CODES_DEFAULT};
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_bit <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SCROLL;
    cfg_ch.data <= 8'h00;
    bits_sent = 0;
    sender_calm = 0;
    steady = 1'b0;
    hold_request = 1'b0;
    for (int i = 0; i < NumKeyRegs; i++) key_pool[i] = default_code(i);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, default codes
    repeat (3) send_bit(1'b1);
    send_key(SEQ_PRESS, 8'h1C);
    send_key(SEQ_PRESS, 8'h00);
    send_key(SEQ_PRESS, 8'hFF);
    send_key(SEQ_RELEASE, 8'h1C);
    send_key(SEQ_EXT_PRESS, 8'h75);
    send_key(SEQ_EXT_RELEASE, 8'h75);
    send_key(SEQ_RELEASE, CodeExtend);
    send_key(SEQ_RELEASE, CodeRelease);
    send_byte(8'h33);
    send_key(SEQ_EXT_PRESS, CodeExtend);
    send_byte(8'h1C, FRAME_BAD_PARITY);
    send_byte(8'h1C, FRAME_BAD_STOP);
    send_key(SEQ_PRESS, CfgReset.caps);
    send_key(SEQ_PRESS, CfgReset.caps);
    send_key(SEQ_RELEASE, CfgReset.caps);
    send_key(SEQ_PRESS, CfgReset.caps);
    send_key(SEQ_PRESS, CfgReset.left_shift);
    send_key(SEQ_PRESS, CfgReset.right_shift);
    send_key(SEQ_RELEASE, CfgReset.left_shift);
    send_key(SEQ_PRESS, CfgReset.alt);
    send_key(SEQ_PRESS, CfgReset.ctrl);
    send_key(SEQ_EXT_RELEASE, CfgReset.ctrl);
    send_key(SEQ_EXT_PRESS, CfgReset.ctrl);
    send_key(SEQ_RELEASE, CfgReset.alt);
    send_key(SEQ_PRESS, CfgReset.scroll);
    send_key(SEQ_PRESS, CfgReset.num);
    send_key(SEQ_RELEASE, CfgReset.scroll);
    send_key(SEQ_EXT_RELEASE, CfgReset.num);

    foreach (order[k]) begin
      drain();
      load_codes(order[k]);
      random_traffic(PhaseBits);
    end

    // receiver holds off while keys keep coming, so the result queue fills
    hold_request = 1'b1;
    steady = 1'b1;
    repeat (HoldKeys) send_key(SEQ_PRESS, pick_code());
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
